>>> sv/pprc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pprc_pkg
// Types and constants shared by the projected point radius cull core.
// ---------------------------------------------------------------------------
package pprc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_X_LO     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HI     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LO     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HI     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_LO     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W_HI     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd7;

    localparam int MAT_REGS   = 6;
    localparam int RADIUS_W   = 24;

    // divider: dividend = |c + w| * size, divisor = 2 |w|
    localparam int DIV_W      = 81;
    localparam int DIVISOR_W  = 65;
    localparam int QUOT_W     = 17;
    localparam int DIV_CELLS  = QUOT_W;

    // square root of (dx^2 + dy^2) << 16
    localparam int SQ_W       = 52;
    localparam int SQRT_CELLS = 26;

    typedef struct packed {
        logic [31:0]        point_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic [31:0]         kept_id;
        logic [RADIUS_W-1:0] screen_distance;
        logic                batch_end;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic        keep;
        logic        last;
        logic [31:0] id;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIV_W-1:0]     rem_x;
        logic [DIV_W-1:0]     rem_y;
        logic [QUOT_W-1:0]    quot_x;
        logic [QUOT_W-1:0]    quot_y;
        logic                 neg_x;
        logic                 neg_y;
    } div_stage_t;

    typedef struct packed {
        side_t           side;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_stage_t;

endpackage
`default_nettype wire

>>> sv/pprc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pprc_div_cell
// One restoring division step for the x and y lanes: decides quotient bit
// SHIFT against the shared divisor and passes the item to the next cell.
// ---------------------------------------------------------------------------
module pprc_div_cell #(
    parameter int SHIFT = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire pprc_pkg::div_stage_t d,
    output pprc_pkg::div_stage_t      q
);

    pprc_pkg::div_stage_t stage_reg;
    pprc_pkg::div_stage_t stage_next;
    logic [pprc_pkg::DIV_W-1:0] step;
    logic ge_x;
    logic ge_y;

    always_comb
    begin
        step = pprc_pkg::DIV_W'(d.divisor) << SHIFT;
        ge_x = d.rem_x >= step;
        ge_y = d.rem_y >= step;
        stage_next = d;
        if (ge_x)
        begin
            stage_next.rem_x = d.rem_x - step;
        end
        if (ge_y)
        begin
            stage_next.rem_y = d.rem_y - step;
        end
        stage_next.quot_x[SHIFT] = ge_x;
        stage_next.quot_y[SHIFT] = ge_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.side.valid <= 1'b0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign q = stage_reg;

endmodule
`default_nettype wire

>>> sv/pprc_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pprc_sqrt_cell
// One digit of the bitwise integer square root (trial bit 4^K), then
// hands the partial root and remainder to the next cell.
// ---------------------------------------------------------------------------
module pprc_sqrt_cell #(
    parameter int K = 25
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire pprc_pkg::sqrt_stage_t d,
    output pprc_pkg::sqrt_stage_t      q
);

    localparam logic [pprc_pkg::SQ_W-1:0] BIT = pprc_pkg::SQ_W'(1) << (2 * K);

    pprc_pkg::sqrt_stage_t stage_reg;
    pprc_pkg::sqrt_stage_t stage_next;
    logic [pprc_pkg::SQ_W-1:0] trial;

    always_comb
    begin
        trial = d.root + BIT;
        stage_next = d;
        if (d.rem >= trial)
        begin
            stage_next.rem  = d.rem - trial;
            stage_next.root = (d.root >> 1) + BIT;
        end
        else
        begin
            stage_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.side.valid <= 1'b0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign q = stage_reg;

endmodule
`default_nettype wire

>>> sv/projected_point_radius_cull_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// projected_point_radius_cull_core
// Projects points through the view-projection matrix, maps them to window
// pixels and keeps those within the configured circle.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid / in_stall | in_data  (pprc_pkg::in_item_t)
//  out     | output    | out_valid/out_stall | out_data (pprc_pkg::out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled; 8 datapath stages, 17
//  divider cells, 26 square root cells and an output register.
//  Dropped points (zero w, outside radius) leave no output item.
//  Reset clears all stage valids and loads the default registers.
//  A waiting output item freezes the whole pipeline and stalls the input.
// ---------------------------------------------------------------------------
module projected_point_radius_cull_core #(
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire pprc_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output pprc_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pprc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [63:0]                        cfg_data
);

    // ---------------- configuration ----------------
    logic [63:0] mat_reg [pprc_pkg::MAT_REGS];
    logic [63:0] geom_reg;
    logic [pprc_pkg::RADIUS_W-1:0] radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[1] <= 64'h0;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[3] <= 64'h0;
            mat_reg[4] <= 64'h0;
            mat_reg[5] <= 64'h0001_0000_0000_0000;
            geom_reg   <= 64'd152000610663139200;
            radius_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                [pprc_pkg::REG_X_LO:pprc_pkg::REG_W_HI]:
                    mat_reg[cfg_index[2:0]] <= cfg_data;
                pprc_pkg::REG_GEOMETRY:
                    geom_reg <= cfg_data;
                pprc_pkg::REG_RADIUS:
                    radius_reg <= cfg_data[pprc_pkg::RADIUS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic adv;
    logic out_valid_reg;
    pprc_pkg::out_item_t out_data_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------- S1: products ----------------
    logic signed [63:0] prod_next [9];
    logic signed [63:0] prod_reg  [9];
    pprc_pkg::side_t s1_side_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_next[3*r]   = 64'($signed(mat_reg[3'(2*r)][31:0]))   * 64'(in_data.pos_x);
            prod_next[3*r+1] = 64'($signed(mat_reg[3'(2*r)][63:32]))  * 64'(in_data.pos_y);
            prod_next[3*r+2] = 64'($signed(mat_reg[3'(2*r+1)][31:0])) * 64'(in_data.pos_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_side_reg.valid <= in_valid;
            s1_side_reg.keep  <= 1'b1;
            s1_side_reg.last  <= in_data.last_point;
            s1_side_reg.id    <= in_data.point_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    // ---------------- S2: clip coordinates ----------------
    logic signed [63:0] clip_next [3];
    logic signed [63:0] clip_reg  [3];
    pprc_pkg::side_t s2_side_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            // arithmetic shift is the floor of each term
            clip_next[r] = (prod_reg[3*r] >>> POSITION_FRACTION_BITS)
                         + (prod_reg[3*r+1] >>> POSITION_FRACTION_BITS)
                         + (prod_reg[3*r+2] >>> POSITION_FRACTION_BITS)
                         + 64'($signed(mat_reg[3'(2*r+1)][63:32]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clip_reg <= clip_next;
        end
    end

    // ---------------- S3: magnitudes and signs ----------------
    logic signed [63:0] num_x;
    logic signed [63:0] num_y;
    logic [63:0] abs_w;
    logic [63:0] mag_x_reg;
    logic [63:0] mag_y_reg;
    logic        neg_x_reg;
    logic        neg_y_reg;
    logic [pprc_pkg::DIVISOR_W-1:0] divisor_reg;
    pprc_pkg::side_t s3_side_reg;

    always_comb
    begin
        num_x = clip_reg[0] + clip_reg[2];
        num_y = clip_reg[1] + clip_reg[2];
        abs_w = clip_reg[2][63] ? 64'(-clip_reg[2]) : 64'(clip_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s3_side_reg.valid <= s2_side_reg.valid;
            s3_side_reg.keep  <= s2_side_reg.keep && (clip_reg[2] != 64'sd0);
            s3_side_reg.last  <= s2_side_reg.last;
            s3_side_reg.id    <= s2_side_reg.id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg   <= num_x[63] ? 64'(-num_x) : 64'(num_x);
            mag_y_reg   <= num_y[63] ? 64'(-num_y) : 64'(num_y);
            neg_x_reg   <= num_x[63] ^ clip_reg[2][63];
            neg_y_reg   <= num_y[63] ^ clip_reg[2][63];
            divisor_reg <= {abs_w, 1'b0};
        end
    end

    // ---------------- S4: partial products with window size ----------------
    logic [47:0] px_lo_reg;
    logic [47:0] px_hi_reg;
    logic [47:0] py_lo_reg;
    logic [47:0] py_hi_reg;
    logic        neg_x4_reg;
    logic        neg_y4_reg;
    logic [pprc_pkg::DIVISOR_W-1:0] divisor4_reg;
    pprc_pkg::side_t s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s4_side_reg <= s3_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_lo_reg    <= 48'(mag_x_reg[31:0])  * 48'(geom_reg[15:0]);
            px_hi_reg    <= 48'(mag_x_reg[63:32]) * 48'(geom_reg[15:0]);
            py_lo_reg    <= 48'(mag_y_reg[31:0])  * 48'(geom_reg[31:16]);
            py_hi_reg    <= 48'(mag_y_reg[63:32]) * 48'(geom_reg[31:16]);
            neg_x4_reg   <= neg_x_reg;
            neg_y4_reg   <= neg_y_reg;
            divisor4_reg <= divisor_reg;
        end
    end

    // ---------------- S5: dividend, enters divider row ----------------
    pprc_pkg::div_stage_t div_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg.side.valid <= 1'b0;
        end
        else if (adv)
        begin
            div_in_reg.side    <= s4_side_reg;
            div_in_reg.divisor <= divisor4_reg;
            div_in_reg.rem_x   <= (pprc_pkg::DIV_W'(px_hi_reg) << 32)
                                + pprc_pkg::DIV_W'(px_lo_reg);
            div_in_reg.rem_y   <= (pprc_pkg::DIV_W'(py_hi_reg) << 32)
                                + pprc_pkg::DIV_W'(py_lo_reg);
            div_in_reg.quot_x  <= '0;
            div_in_reg.quot_y  <= '0;
            div_in_reg.neg_x   <= neg_x4_reg;
            div_in_reg.neg_y   <= neg_y4_reg;
        end
    end

    pprc_pkg::div_stage_t div_bus [pprc_pkg::DIV_CELLS+1];
    assign div_bus[0] = div_in_reg;

    for (genvar j = 0; j < pprc_pkg::DIV_CELLS; j++)
    begin : g_div
        pprc_div_cell #(
            .SHIFT(pprc_pkg::DIV_CELLS - 1 - j)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .d    (div_bus[j]),
            .q    (div_bus[j+1])
        );
    end

    // ---------------- S6: saturate, offset from center ----------------
    pprc_pkg::div_stage_t div_out;
    logic signed [16:0] scr_x;
    logic signed [16:0] scr_y;
    logic signed [17:0] dx_reg;
    logic signed [17:0] dy_reg;
    pprc_pkg::side_t s6_side_reg;

    assign div_out = div_bus[pprc_pkg::DIV_CELLS];

    function automatic logic signed [16:0] saturate(
        input logic [pprc_pkg::QUOT_W-1:0] quot,
        input logic                        neg
    );
        logic signed [16:0] res;
        if (neg)
        begin
            res = (quot > 17'd32768) ? -17'sd32768 : $signed(17'd0 - quot);
        end
        else
        begin
            res = (quot > 17'd32767) ? 17'sd32767 : $signed(quot);
        end
        return res;
    endfunction

    always_comb
    begin
        scr_x = saturate(div_out.quot_x, div_out.neg_x);
        scr_y = saturate(div_out.quot_y, div_out.neg_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s6_side_reg <= div_out.side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= 18'(scr_x) - $signed({2'b00, geom_reg[47:32]});
            dy_reg <= 18'(scr_y) - $signed({2'b00, geom_reg[63:48]});
        end
    end

    // ---------------- S7: squares ----------------
    logic signed [35:0] sq_x;
    logic signed [35:0] sq_y;
    logic [33:0] sq_x_reg;
    logic [33:0] sq_y_reg;
    pprc_pkg::side_t s7_side_reg;

    assign sq_x = dx_reg * dx_reg;
    assign sq_y = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s7_side_reg <= s6_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x_reg <= sq_x[33:0];
            sq_y_reg <= sq_y[33:0];
        end
    end

    // ---------------- S8: sum, enters square root row ----------------
    pprc_pkg::sqrt_stage_t sqrt_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_in_reg.side.valid <= 1'b0;
        end
        else if (adv)
        begin
            sqrt_in_reg.side <= s7_side_reg;
            sqrt_in_reg.rem  <= pprc_pkg::SQ_W'({(35'(sq_x_reg) + 35'(sq_y_reg)), 16'h0});
            sqrt_in_reg.root <= '0;
        end
    end

    pprc_pkg::sqrt_stage_t sqrt_bus [pprc_pkg::SQRT_CELLS+1];
    assign sqrt_bus[0] = sqrt_in_reg;

    for (genvar j = 0; j < pprc_pkg::SQRT_CELLS; j++)
    begin : g_sqrt
        pprc_sqrt_cell #(
            .K(pprc_pkg::SQRT_CELLS - 1 - j)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .d    (sqrt_bus[j]),
            .q    (sqrt_bus[j+1])
        );
    end

    // ---------------- output register ----------------
    pprc_pkg::sqrt_stage_t sqrt_out;
    logic hit;

    assign sqrt_out = sqrt_bus[pprc_pkg::SQRT_CELLS];
    assign hit = sqrt_out.side.valid && sqrt_out.side.keep
              && (sqrt_out.root <= pprc_pkg::SQ_W'(radius_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && hit)
        begin
            out_data_reg.kept_id         <= sqrt_out.side.id;
            out_data_reg.screen_distance <= sqrt_out.root[pprc_pkg::RADIUS_W-1:0];
            out_data_reg.batch_end       <= sqrt_out.side.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

>>> sv/pprc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pprc_checker
// Port-level checks for the cull core, bound to the top level.
// ---------------------------------------------------------------------------
module pprc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire pprc_pkg::in_item_t             in_data,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire pprc_pkg::out_item_t            out_data,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic [pprc_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [63:0]                    cfg_data
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output item changed under stall");

    // a waiting output item blocks the input side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output blocked");

    // an empty output register never stalls the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind projected_point_radius_cull_core pprc_checker u_pprc_checker (.*);
`default_nettype wire

>>> dv/pprc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pprc_scoreboard
// Watches the config, input and output channels of the cull core, predicts
// the kept points from its own copy of the registers and compares each
// output item in order.
// ---------------------------------------------------------------------------
module pprc_scoreboard #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  pprc_pkg::in_item_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  pprc_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pprc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                         cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    logic [63:0]         shadow [8];
    pprc_pkg::out_item_t kept_q [$];
    int                  errs;

    function automatic longint row_sum(logic [63:0] lo, logic [63:0] hi,
                                       longint px, longint py, longint pz);
        longint m0, m1, m2, m3;
        m0 = longint'($signed(lo[31:0]));
        m1 = longint'($signed(lo[63:32]));
        m2 = longint'($signed(hi[31:0]));
        m3 = longint'($signed(hi[63:32]));
        // each term floors on its own
        return ((m0 * px) >>> FRAC_BITS) + ((m1 * py) >>> FRAC_BITS)
             + ((m2 * pz) >>> FRAC_BITS) + m3;
    endfunction

    function automatic longint pixel(longint c, longint w, logic [15:0] size);
        longint      n;
        logic        neg;
        logic [127:0] a, b, q;
        n   = c + w;
        neg = (n < 0) != (w < 0);
        a   = 128'(n < 0 ? -n : n);
        b   = 128'(w < 0 ? -w : w) << 1;
        if (size == 16'd0)
            return 0;
        q = (a * 128'(size)) / b;
        if (neg)
            return (q > 128'd32768) ? -32768 : -longint'(q[63:0]);
        return (q > 128'd32767) ? 32767 : longint'(q[63:0]);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic predict_point(pprc_pkg::in_item_t p);
        longint              px, py, pz, cx, cy, cw, sx, sy, dx, dy;
        logic [63:0]         sq, dist_val;
        pprc_pkg::out_item_t e;
        px = longint'(p.pos_x);
        py = longint'(p.pos_y);
        pz = longint'(p.pos_z);
        cx = row_sum(shadow[pprc_pkg::REG_X_LO], shadow[pprc_pkg::REG_X_HI], px, py, pz);
        cy = row_sum(shadow[pprc_pkg::REG_Y_LO], shadow[pprc_pkg::REG_Y_HI], px, py, pz);
        cw = row_sum(shadow[pprc_pkg::REG_W_LO], shadow[pprc_pkg::REG_W_HI], px, py, pz);
        if (cw == 0)
            return;
        sx = pixel(cx, cw, shadow[pprc_pkg::REG_GEOMETRY][15:0]);
        sy = pixel(cy, cw, shadow[pprc_pkg::REG_GEOMETRY][31:16]);
        dx = sx - longint'({48'd0, shadow[pprc_pkg::REG_GEOMETRY][47:32]});
        dy = sy - longint'({48'd0, shadow[pprc_pkg::REG_GEOMETRY][63:48]});
        sq = 64'(dx * dx) + 64'(dy * dy);
        dist_val = int_sqrt(sq << 16);
        if (dist_val > {40'd0, shadow[pprc_pkg::REG_RADIUS][23:0]})
            return;
        e.kept_id         = p.point_id;
        e.screen_distance = dist_val[23:0];
        e.batch_end       = p.last_point;
        kept_q = {kept_q, e};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow[0] <= 64'd65536;
            shadow[1] <= 64'd0;
            shadow[2] <= 64'd281474976710656;
            shadow[3] <= 64'd0;
            shadow[4] <= 64'd0;
            shadow[5] <= 64'd281474976710656;
            shadow[6] <= 64'd152000610663139200;
            shadow[7] <= 64'd0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready && cfg_index < 8)
                shadow[cfg_index] <= (cfg_index == pprc_pkg::REG_RADIUS) ?
                                     {40'd0, cfg_data[23:0]} : cfg_data;
            if (in_valid && !in_stall)
                predict_point(in_data);
            if (out_valid && !out_stall)
            begin
                if (kept_q.size() == 0)
                begin
                    $error("unexpected output item id %0h", out_data.kept_id);
                    errs = errs + 1;
                end
                else
                begin
                    pprc_pkg::out_item_t e;
                    e = kept_q.pop_front();
                    if (e.kept_id !== out_data.kept_id)
                    begin
                        $error("kept_id exp %0h got %0h", e.kept_id, out_data.kept_id);
                        errs = errs + 1;
                    end
                    if (e.screen_distance !== out_data.screen_distance)
                    begin
                        $error("screen_distance exp %0h got %0h",
                               e.screen_distance, out_data.screen_distance);
                        errs = errs + 1;
                    end
                    if (e.batch_end !== out_data.batch_end)
                    begin
                        $error("batch_end exp %0b got %0b", e.batch_end, out_data.batch_end);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= kept_q.size();
        end
    end
endmodule

>>> dv/tb_projected_point_radius_cull_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_projected_point_radius_cull_core
// Streams directed and random points through the cull core under several
// matrix and window settings with random gaps and back-pressure.
// ---------------------------------------------------------------------------
module tb_projected_point_radius_cull_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic                second_dummy_unused_guard;
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    pprc_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    pprc_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [pprc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    int          send_gap_pct;
    int          recv_stall_pct;
    int unsigned next_id;

    projected_point_radius_cull_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pprc_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic write_reg(logic [pprc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one fixed-point matrix word: mostly within +-2.0, sometimes any value
    function automatic logic [31:0] rand_coef();
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'($signed($urandom_range(262144)) - 131072);
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8192)) - 4096);
            default: return 32'($signed($urandom_range(524288)) - 262144);
        endcase
    endfunction

    task automatic load_matrix(logic [31:0] m [12]);
        write_reg(pprc_pkg::REG_X_LO, {m[1], m[0]});
        write_reg(pprc_pkg::REG_X_HI, {m[3], m[2]});
        write_reg(pprc_pkg::REG_Y_LO, {m[5], m[4]});
        write_reg(pprc_pkg::REG_Y_HI, {m[7], m[6]});
        write_reg(pprc_pkg::REG_W_LO, {m[9], m[8]});
        write_reg(pprc_pkg::REG_W_HI, {m[11], m[10]});
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic last);
        int gap;
        @(negedge clk);
        if ($urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{point_id: next_id, pos_x: x, pos_y: y, pos_z: z, last_point: last};
        next_id  = next_id + 32'h9E37_79B9;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    logic [31:0] mat [12];
    int          phase;
    int          k;

    initial
    begin
        cycles         = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        next_id        = 32'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: default identity projection, widest radius
        write_reg(pprc_pkg::REG_RADIUS, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h0000_8000, 32'h0000_8000, 32'd0, 1'b0);
        stop_sending();
        wait_idle();

        // w taken from x: zero w, zero width, center at the corner
        mat = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0,
                32'h0001_0000, 0, 0, 0};
        load_matrix(mat);
        write_reg(pprc_pkg::REG_GEOMETRY, {16'd0, 16'd0, 16'd480, 16'd0});
        write_reg(pprc_pkg::REG_RADIUS, 64'd2560);
        send_point(32'd0, 32'h0001_0000, 32'd5, 1'b1);
        send_point(32'h0001_0000, 32'h0001_0000, 32'd0, 1'b0);
        send_point(32'hFFFF_0000, 32'h0002_0000, 32'd0, 1'b1);
        send_point(32'h0000_0001, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_point(32'h8000_0000, 32'h0000_0000, 32'd0, 1'b1);
        send_point(32'h0000_4000, 32'hFFFF_C000, 32'd0, 1'b0);
        stop_sending();
        wait_idle();

        // extreme register values, radius zero
        mat = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 32'h0000_0001, 32'd0, 32'h0000_0001};
        load_matrix(mat);
        write_reg(pprc_pkg::REG_GEOMETRY, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pprc_pkg::REG_RADIUS, 64'd0);
        send_point(32'd0, 32'd0, 32'd0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        stop_sending();
        wait_idle();

        for (phase = 0; phase < 6; phase++)
        begin
            send_gap_pct   = (phase < 2) ? 18 : (phase < 4) ? 54 : 0;
            recv_stall_pct = (phase < 2) ? 54 : (phase < 4) ? 18 : 0;
            foreach (mat[i])
                mat[i] = rand_coef();
            // keep w mostly positive and near 1.0
            if (phase != 5)
                mat[11] = 32'h0001_0000 + ($urandom_range(65535) & 32'h0000_FFFF);
            load_matrix(mat);
            write_reg(pprc_pkg::REG_GEOMETRY, {$urandom, $urandom} &
                      ((phase == 4) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h07FF_07FF_0FFF_0FFF));
            write_reg(pprc_pkg::REG_RADIUS, (phase == 1) ? 64'hFF_FFFF :
                      {40'd0, 24'($urandom_range(24'hFF_FFFF))});
            for (k = 0; k < 130; k++)
            begin
                if (k == 65)
                begin
                    stop_sending();
                    while (pending != 0)
                        @(posedge clk);
                end
                send_point(rand_pos(), rand_pos(), rand_pos(), $urandom_range(7) == 0);
            end
            stop_sending();
            wait_idle();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
sv/pprc_pkg.sv
sv/pprc_div_cell.sv
sv/pprc_sqrt_cell.sv
sv/projected_point_radius_cull_core.sv
sv/pprc_checker.sv
dv/pprc_checker.sv
dv/tb_projected_point_radius_cull_core.sv
